// ----- hw/rtl/smac_pkg.sv -----
// ----------------------------------------------------------------------------
// Shadow memory access checker package
// Shared widths, codes, controller states and control/status structs.
// ----------------------------------------------------------------------------
package smac_pkg;

    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned SIZE_W   = 3;
    localparam int unsigned WIDX_W   = 6;
    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned BYTES_W  = 13;
    localparam int unsigned CFG_AW   = 5;
    localparam int unsigned CFG_DW   = 64;
    localparam int unsigned CFG_IW   = 2;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_CHECK        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_VALID   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_DEFINED = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_STACK_LOW   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_STACK_BYTES = 2'd1;
    localparam logic [CFG_IW-1:0] REG_HEAP_LOW    = 2'd2;
    localparam logic [CFG_IW-1:0] REG_HEAP_BYTES  = 2'd3;

    // Size codes.
    localparam logic [SIZE_W-1:0] SIZE_16 = 3'd4;
    localparam logic [SIZE_W-1:0] SIZE_32 = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_REGN,
        S_MEASURE,
        S_READ,
        S_CHECK,
        S_WRLO,
        S_WRHI,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [ADDR_W-1:0] address;
        logic [SIZE_W-1:0]        size_code;
        logic                     exempt_alignment;
        logic                     may_read;
        logic                     may_write;
        logic                     region_select;
        logic [WIDX_W-1:0]        word_index;
        logic [WORD_W-1:0]        word_data;
    } t_item;

    typedef struct packed {
        logic capture;
        logic load;
        logic regn;
        logic measure;
        logic read;
        logic check;
        logic wr_lo;
        logic wr_hi;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic in_check;
        logic in_load;
        logic commit;
        logic hi_needed;
        logic out_free;
    } t_sts;

endpackage

// ----- hw/rtl/smac_if.sv -----
// ----------------------------------------------------------------------------
// Shadow memory access checker channels
// Request channel (access checks and map loads) and response channel.
// ----------------------------------------------------------------------------
interface smac_req_if;
    logic                               valid;
    logic                               ready;
    logic [smac_pkg::KIND_W-1:0]        kind;
    logic signed [smac_pkg::ADDR_W-1:0] address;
    logic [smac_pkg::SIZE_W-1:0]        size_code;
    logic                               exempt_alignment;
    logic                               may_read;
    logic                               may_write;
    logic                               region_select;
    logic [smac_pkg::WIDX_W-1:0]        word_index;
    logic [smac_pkg::WORD_W-1:0]        word_data;

    modport source (
        output valid, kind, address, size_code, exempt_alignment, may_read,
               may_write, region_select, word_index, word_data,
        input  ready
    );
    modport sink (
        input  valid, kind, address, size_code, exempt_alignment, may_read,
               may_write, region_select, word_index, word_data,
        output ready
    );
endinterface

interface smac_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          fault;
    logic                          region;
    logic [smac_pkg::OFFSET_W-1:0] offset;

    modport source (output valid, fault, region, offset, input ready);
    modport sink (input valid, fault, region, offset, output ready);
endinterface

// ----- hw/rtl/smac_ctrl.sv -----
// ----------------------------------------------------------------------------
// Shadow memory access checker controller
// Sequences one word at a time through the datapath steps.
// ----------------------------------------------------------------------------
module smac_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  smac_pkg::t_sts  i_sts,
    output smac_pkg::t_cmd  o_cmd
);
    import smac_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.in_check) begin
                        n_state = S_REGN;
                    end else if (i_sts.in_load) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            S_REGN: begin
                o_cmd.regn = 1'b1;
                n_state    = S_MEASURE;
            end
            S_MEASURE: begin
                o_cmd.measure = 1'b1;
                n_state       = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.commit ? S_WRLO : S_PUSH;
            end
            S_WRLO: begin
                o_cmd.wr_lo = 1'b1;
                n_state     = i_sts.hi_needed ? S_WRHI : S_PUSH;
            end
            S_WRHI: begin
                o_cmd.wr_hi = 1'b1;
                n_state     = S_PUSH;
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // An accepted check word starts the region step.
    a_check_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_sts.in_check) |=> (r_state == S_REGN))
        else $error("check word did not start region step");

    // Write-back only follows a passing check.
    a_wrlo_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRLO) |-> ($past(r_state) == S_CHECK))
        else $error("write-back without check");

    // The upper word write is the last write-back step.
    a_wrhi_then_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRHI) |=> (r_state == S_PUSH))
        else $error("upper write not followed by push");
`endif

endmodule

// ----- hw/rtl/smac_dp.sv -----
// ----------------------------------------------------------------------------
// Shadow memory access checker datapath
// Configuration registers, shadow bitmaps, range and map checks, result register.
// ----------------------------------------------------------------------------
module smac_dp #(
    parameter int unsigned REGION_BYTES = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  smac_pkg::t_item                  i_item,
    input  smac_pkg::t_cmd                   i_cmd,
    output smac_pkg::t_sts                   o_sts,
    input  logic                             i_cfg_we,
    input  logic [smac_pkg::CFG_IW-1:0]      i_cfg_idx,
    input  logic [smac_pkg::CFG_DW-1:0]      i_cfg_wdata,
    output logic [smac_pkg::CFG_DW-1:0]      o_cfg_rdata,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_out_fault,
    output logic                             o_out_region,
    output logic [smac_pkg::OFFSET_W-1:0]    o_out_offset
);
    import smac_pkg::*;

    localparam int unsigned MAP_WORDS = (REGION_BYTES + 63) / 64;
    localparam int unsigned IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned LIM_W     = $clog2(REGION_BYTES + 1);
    localparam int unsigned SUM_W     = LIM_W + 1;

    // Configuration registers.
    logic signed [ADDR_W-1:0] r_stack_low;
    logic [BYTES_W-1:0]       r_stack_bytes;
    logic signed [ADDR_W-1:0] r_heap_low;
    logic [BYTES_W-1:0]       r_heap_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_low   <= '0;
            r_stack_bytes <= '0;
            r_heap_low    <= '0;
            r_heap_bytes  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STACK_LOW:   r_stack_low   <= i_cfg_wdata;
                REG_STACK_BYTES: r_stack_bytes <= i_cfg_wdata[BYTES_W-1:0];
                REG_HEAP_LOW:    r_heap_low    <= i_cfg_wdata;
                REG_HEAP_BYTES:  r_heap_bytes  <= i_cfg_wdata[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_cfg_idx)
            REG_STACK_LOW:   o_cfg_rdata = r_stack_low;
            REG_STACK_BYTES: o_cfg_rdata = CFG_DW'(r_stack_bytes);
            REG_HEAP_LOW:    o_cfg_rdata = r_heap_low;
            REG_HEAP_BYTES:  o_cfg_rdata = CFG_DW'(r_heap_bytes);
            default:         o_cfg_rdata = '0;
        endcase
    end

    // Captured word; size codes past 32 bytes act as 32 bytes.
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item = i_item;
        if (i_item.size_code > SIZE_32) begin
            n_item.size_code = SIZE_32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= n_item;
        end
    end

    // Region choice, clamped limit and alignment check.
    logic                     r_heap;
    logic signed [ADDR_W-1:0] r_base;
    logic [LIM_W-1:0]         r_limit;
    logic                     r_align_fault;
    logic [BYTES_W-1:0]       sel_bytes;
    logic                     sel_heap;

    assign sel_heap  = $signed(r_item.address) < $signed(r_stack_low);
    assign sel_bytes = sel_heap ? r_heap_bytes : r_stack_bytes;

    always_ff @(posedge i_clk) begin
        if (i_cmd.regn) begin
            r_heap  <= sel_heap;
            r_base  <= sel_heap ? r_heap_low : r_stack_low;
            r_limit <= (32'(sel_bytes) > 32'(REGION_BYTES)) ?
                       LIM_W'(REGION_BYTES) : LIM_W'(sel_bytes);
            r_align_fault <= !r_item.exempt_alignment && (
                ((r_item.size_code == SIZE_16) && (r_item.address[3:0] != 4'd0)) ||
                ((r_item.size_code == SIZE_32) && (r_item.address[4:0] != 5'd0)));
        end
    end

    // Exact distance from the region base and range check.
    logic [ADDR_W:0]  diff;
    logic             range_fault;
    logic [LIM_W-1:0] r_off;
    logic             r_pre_fault;

    assign diff = {r_item.address[ADDR_W-1], r_item.address} -
                  {r_base[ADDR_W-1], r_base};
    assign range_fault = diff[ADDR_W] || (|diff[ADDR_W-1:LIM_W]) ||
                         (diff[LIM_W-1:0] >= r_limit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.measure) begin
            r_off       <= diff[LIM_W-1:0];
            r_pre_fault <= r_align_fault || range_fault;
        end
    end

    // Shadow bitmaps with per-word valid bits for reset.
    logic [WORD_W-1:0]    m_sdef [MAP_WORDS];
    logic [WORD_W-1:0]    m_sval [MAP_WORDS];
    logic [WORD_W-1:0]    m_hdef [MAP_WORDS];
    logic [WORD_W-1:0]    m_hval [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_sdef_vld;
    logic [MAP_WORDS-1:0] r_sval_vld;
    logic [MAP_WORDS-1:0] r_hdef_vld;
    logic [MAP_WORDS-1:0] r_hval_vld;

    logic [IDX_W-1:0]  w0;
    logic [IDX_W-1:0]  w1;
    logic              w1_in;
    logic [IDX_W-1:0]  r_w0;
    logic [IDX_W-1:0]  r_w1;
    logic              load_in;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              we_sdef;
    logic              we_sval;
    logic              we_hdef;
    logic              we_hval;

    // Map words read for the access and the byte masks kept for write-back.
    logic [WORD_W-1:0] r_def_lo;
    logic [WORD_W-1:0] r_def_hi;
    logic [WORD_W-1:0] r_val_lo;
    logic [WORD_W-1:0] r_val_hi;
    logic [WORD_W-1:0] r_mlo;
    logic [WORD_W-1:0] r_mhi;

    assign w0    = IDX_W'(r_off >> 6);
    assign w1_in = (32'(w0) + 32'd1) < 32'(MAP_WORDS);
    assign w1    = w1_in ? IDX_W'(32'(w0) + 32'd1) : '0;

    assign load_in = 32'(r_item.word_index) < 32'(MAP_WORDS);

    // Write port: map loads and defined-map write-back.
    always_comb begin
        we_sdef = 1'b0;
        we_sval = 1'b0;
        we_hdef = 1'b0;
        we_hval = 1'b0;
        waddr   = r_w0;
        wdata   = r_item.word_data;
        if (i_cmd.load && load_in) begin
            waddr = IDX_W'(r_item.word_index);
            if (r_item.kind == KIND_LOAD_VALID) begin
                we_sval = !r_item.region_select;
                we_hval = r_item.region_select;
            end else begin
                we_sdef = !r_item.region_select;
                we_hdef = r_item.region_select;
            end
        end else if (i_cmd.wr_lo || i_cmd.wr_hi) begin
            we_sdef = !r_heap;
            we_hdef = r_heap;
        end
        if (i_cmd.wr_lo) begin
            waddr = r_w0;
            wdata = r_def_lo | r_mlo;
        end else if (i_cmd.wr_hi) begin
            waddr = r_w1;
            wdata = r_def_hi | r_mhi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_sdef) m_sdef[waddr] <= wdata;
        if (we_sval) m_sval[waddr] <= wdata;
        if (we_hdef) m_hdef[waddr] <= wdata;
        if (we_hval) m_hval[waddr] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sdef_vld <= '0;
            r_sval_vld <= '0;
            r_hdef_vld <= '0;
            r_hval_vld <= '0;
        end else begin
            if (we_sdef) r_sdef_vld[waddr] <= 1'b1;
            if (we_sval) r_sval_vld[waddr] <= 1'b1;
            if (we_hdef) r_hdef_vld[waddr] <= 1'b1;
            if (we_hval) r_hval_vld[waddr] <= 1'b1;
        end
    end

    // Read ports: the two words an access can touch, never-written words read as zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_w0 <= w0;
            r_w1 <= w1;
            if (r_heap) begin
                r_def_lo <= m_hdef[w0] & {WORD_W{r_hdef_vld[w0]}};
                r_val_lo <= m_hval[w0] & {WORD_W{r_hval_vld[w0]}};
                r_def_hi <= m_hdef[w1] & {WORD_W{r_hdef_vld[w1] & w1_in}};
                r_val_hi <= m_hval[w1] & {WORD_W{r_hval_vld[w1] & w1_in}};
            end else begin
                r_def_lo <= m_sdef[w0] & {WORD_W{r_sdef_vld[w0]}};
                r_val_lo <= m_sval[w0] & {WORD_W{r_sval_vld[w0]}};
                r_def_hi <= m_sdef[w1] & {WORD_W{r_sdef_vld[w1] & w1_in}};
                r_val_hi <= m_sval[w1] & {WORD_W{r_sval_vld[w1] & w1_in}};
            end
        end
    end

    // Byte masks and map checks.
    logic [5:0]          size;
    logic [WORD_W-1:0]   mbase;
    logic [2*WORD_W-1:0] m128;
    logic [WORD_W-1:0]   mlo;
    logic [WORD_W-1:0]   mhi;
    logic                span_fault;
    logic                map_fault;
    logic                fault_c;
    logic                r_fault;

    assign size  = 6'd1 << r_item.size_code;
    assign mbase = (WORD_W'(1) << size) - WORD_W'(1);
    assign m128  = {{WORD_W{1'b0}}, mbase} << r_off[5:0];
    assign mlo   = m128[WORD_W-1:0];
    assign mhi   = m128[2*WORD_W-1:WORD_W];

    assign span_fault = (r_item.may_read || r_item.may_write) &&
                        ((SUM_W'(r_off) + SUM_W'(size)) > SUM_W'(r_limit));
    assign map_fault =
        (r_item.may_read  && (((r_def_lo & mlo) != mlo) || ((r_def_hi & mhi) != mhi))) ||
        (r_item.may_write && (((r_val_lo & mlo) != mlo) || ((r_val_hi & mhi) != mhi)));
    assign fault_c = r_pre_fault || span_fault || map_fault;

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_fault <= fault_c;
            r_mlo   <= mlo;
            r_mhi   <= mhi;
        end
    end

    // Result register.
    logic                r_out_valid;
    logic                r_out_fault;
    logic                r_out_region;
    logic [OFFSET_W-1:0] r_out_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_fault  <= r_fault;
            r_out_region <= !r_fault && r_heap;
            r_out_offset <= r_fault ? '0 : OFFSET_W'(r_off);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_fault  = r_out_fault;
    assign o_out_region = r_out_region;
    assign o_out_offset = r_out_offset;

    // Status to the controller.
    assign o_sts.in_check  = (i_item.kind == KIND_CHECK);
    assign o_sts.in_load   = (i_item.kind == KIND_LOAD_VALID) ||
                             (i_item.kind == KIND_LOAD_DEFINED);
    assign o_sts.commit    = !fault_c && r_item.may_write;
    assign o_sts.hi_needed = (r_mhi != '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

// ----- hw/rtl/shadow_memory_access_checker.sv -----
// ----------------------------------------------------------------------------
// Shadow memory access checker
// Checks memory accesses against stack and heap shadow bitmaps.
// ----------------------------------------------------------------------------
// Words arrive on i_req. A check word (kind 0) yields one word on o_rsp with
// fault, region and offset; a map load word (kind 1 or 2) writes one 64-bit
// valid or defined map word and yields nothing. Region bounds are set through
// the APB port, one 64-bit register every 8 bytes; the user must write them
// only while the block is idle, which the block itself does not enforce.
// A check word steps through region select, exact distance, map read and
// check, then write-back of one or two defined map words when it passes
// and writes, and result push. A load word writes its map word and the block
// returns to idle. The block handles one word at a time.
// The result register lets the next word be accepted while a result still
// waits; if o_rsp stays stalled the following check waits in its push step.
// Reset clears the region registers, marks every map word as zero through
// per-word valid bits, and empties the result register; no clearing pass.
// ----------------------------------------------------------------------------
module shadow_memory_access_checker #(
    parameter int unsigned REGION_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    smac_req_if.sink                      i_req,
    smac_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [smac_pkg::CFG_AW-1:0]   paddr,
    input  logic [smac_pkg::CFG_DW-1:0]   pwdata,
    output logic [smac_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);
    import smac_pkg::*;

    t_item item;
    t_cmd  cmd;
    t_sts  sts;
    logic  cfg_we;

    // Request word gathered into one struct.
    assign item.kind             = i_req.kind;
    assign item.address          = i_req.address;
    assign item.size_code        = i_req.size_code;
    assign item.exempt_alignment = i_req.exempt_alignment;
    assign item.may_read         = i_req.may_read;
    assign item.may_write        = i_req.may_write;
    assign item.region_select    = i_req.region_select;
    assign item.word_index       = i_req.word_index;
    assign item.word_data        = i_req.word_data;

    // APB access phase write strobe.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    smac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    smac_dp #(
        .REGION_BYTES (REGION_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (paddr[CFG_AW-1:3]),
        .i_cfg_wdata  (pwdata),
        .o_cfg_rdata  (prdata),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_out_fault  (o_rsp.fault),
        .o_out_region (o_rsp.region),
        .o_out_offset (o_rsp.offset)
    );

endmodule
